### hw/rtl/active_particle_heading_position_update_macros.svh
// assertion macros used by the top-level rtl
`ifndef ACTIVE_PARTICLE_HEADING_POSITION_UPDATE_MACROS_SVH
`define ACTIVE_PARTICLE_HEADING_POSITION_UPDATE_MACROS_SVH
// implication checked every clock outside reset
`define APU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/apu_pkg.sv
// shared types and constants for the particle update block
`default_nettype none
package apu_pkg;
    localparam int ANGLE_BITS    = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int GRID_BITS     = 10;
    localparam int POS_BITS      = GRID_BITS + POS_FRAC_BITS;
    localparam int DISP_BITS     = 40;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_W  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_H  = 2'd3;

    typedef struct packed {
        logic [POS_BITS-1:0]         pos_x;
        logic [POS_BITS-1:0]         pos_y;
        logic signed [DISP_BITS-1:0] disp_x;
        logic signed [DISP_BITS-1:0] disp_y;
        logic signed [ANGLE_BITS-1:0] mean_heading;
        logic [15:0]                 noise_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] new_heading;
        logic [POS_BITS-1:0]         new_x;
        logic [POS_BITS-1:0]         new_y;
        logic signed [DISP_BITS-1:0] new_disp_x;
        logic signed [DISP_BITS-1:0] new_disp_y;
    } out_beat_t;
endpackage
`default_nettype wire

### hw/rtl/active_particle_heading_position_update.sv
// top level: vicsek particle heading and position update pipeline
// throughput: one beat per cycle; the pipeline advances whenever the
// output register is empty or being taken, and holds as a whole otherwise
// reset: valid bits clear, registers take speed 32768, eta 15729, box 800 x 100
`default_nettype none
`include "active_particle_heading_position_update_macros.svh"
module active_particle_heading_position_update (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_we,
    input  wire logic [apu_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  wire logic [apu_pkg::CFG_DATA_BITS-1:0]           cfg_data,
    input  wire logic                                        in_valid,
    output logic                                             in_stall,
    input  wire apu_pkg::in_beat_t                           in_data,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output apu_pkg::out_beat_t                               out_data
);
    localparam int AB  = apu_pkg::ANGLE_BITS;
    localparam int PB  = apu_pkg::POS_BITS;
    localparam int DB  = apu_pkg::DISP_BITS;
    localparam int FB  = apu_pkg::POS_FRAC_BITS;
    localparam int GB  = apu_pkg::GRID_BITS;
    localparam int NST = 8;
    localparam int HSH = 32 - AB;
    localparam int SSH = 31 - FB;

    // configuration registers
    logic [15:0]   speed_reg, noise_reg;
    logic [GB-1:0] box_w_reg, box_h_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 16'd32768;
            noise_reg <= 16'd15729;
            box_w_reg <= GB'(800);
            box_h_reg <= GB'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                apu_pkg::REG_SPEED: speed_reg <= cfg_data;
                apu_pkg::REG_NOISE: noise_reg <= cfg_data;
                apu_pkg::REG_BOX_W: box_w_reg <= cfg_data[GB-1:0];
                apu_pkg::REG_BOX_H: box_h_reg <= cfg_data[GB-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; output register acts as last stage
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic [NST-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end
    assign out_valid = v_reg[NST-1];

    // stage 1: eta * (sample - half)
    apu_pkg::in_beat_t   b1_reg;
    logic signed [33:0]  nprod1_reg;
    logic signed [16:0]  dsmp;
    assign dsmp = $signed({1'b0, in_data.noise_sample}) - 17'sd32768;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg     <= in_data;
            nprod1_reg <= $signed({1'b0, noise_reg}) * dsmp;
        end
    end

    // stage 2: round and add to heading
    function automatic logic [AB-1:0] b2_head_sum(input logic [AB-1:0] h,
                                                   input logic signed [33:0] o);
        return h + o[AB-1:0];
    endfunction

    apu_pkg::in_beat_t   b2_reg;
    logic [AB-1:0]       head2_reg;
    logic signed [33:0]  nrnd;
    assign nrnd = (nprod1_reg + (34'sd1 <<< (HSH - 1))) >>> HSH;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_reg    <= b1_reg;
            head2_reg <= AB'(b2_head_sum(b1_reg.mean_heading, nrnd));
        end
    end

    // stages 3..6: sine and cosine
    logic signed [16:0] cos_w, sin_w;
    apu_sin u_cos (.clk(clk), .en(adv),
                   .ang(head2_reg + AB'(1 << (AB - 2))), .sin_q15(cos_w));
    apu_sin u_sin (.clk(clk), .en(adv), .ang(head2_reg), .sin_q15(sin_w));

    apu_pkg::in_beat_t b3_reg, b4_reg, b5_reg, b6_reg;
    logic [AB-1:0]     h3_reg, h4_reg, h5_reg, h6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_reg <= b2_reg; h3_reg <= head2_reg;
            b4_reg <= b3_reg; h4_reg <= h3_reg;
            b5_reg <= b4_reg; h5_reg <= h4_reg;
            b6_reg <= b5_reg; h6_reg <= h5_reg;
        end
    end

    // stage 7: step = round(speed * trig)
    apu_pkg::in_beat_t   b7_reg;
    logic [AB-1:0]       h7_reg;
    logic signed [34:0]  sx_full, sy_full;
    logic signed [34:0]  sx7_reg, sy7_reg;
    assign sx_full = $signed({1'b0, speed_reg}) * cos_w;
    assign sy_full = $signed({1'b0, speed_reg}) * sin_w;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b7_reg  <= b6_reg;
            h7_reg  <= h6_reg;
            sx7_reg <= (sx_full + (35'sd1 <<< (SSH - 1))) >>> SSH;
            sy7_reg <= (sy_full + (35'sd1 <<< (SSH - 1))) >>> SSH;
        end
    end

    // stage 8: wrap and saturate into output register
    function automatic logic [PB-1:0] wrap_pos(input logic [PB-1:0] p,
                                               input logic signed [34:0] st,
                                               input logic [GB-1:0] cells);
        logic signed [PB+1:0] len;
        logic signed [PB+1:0] s;
        len = (cells == '0) ? (PB+2)'(1) <<< PB : $signed((PB+2)'({cells, FB'(0)}));
        s   = $signed({2'b00, p}) + (PB+2)'(st);
        if (s >= len)
            s = s - len;
        else if (s < 0)
            s = s + len;
        return s[PB-1:0];
    endfunction

    function automatic logic [DB-1:0] disp_add(input logic signed [DB-1:0] d,
                                               input logic signed [34:0] st);
        logic signed [DB:0] s;
        s = $signed({d[DB-1], d}) + (DB+1)'(st);
        if (s[DB] != s[DB-1])
            return s[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
        return s[DB-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.new_heading <= h7_reg;
            out_data.new_x       <= wrap_pos(b7_reg.pos_x, sx7_reg, box_w_reg);
            out_data.new_y       <= wrap_pos(b7_reg.pos_y, sy7_reg, box_h_reg);
            out_data.new_disp_x  <= disp_add(b7_reg.disp_x, sx7_reg);
            out_data.new_disp_y  <= disp_add(b7_reg.disp_y, sy7_reg);
        end
    end

    // a held output beat keeps the whole pipeline frozen
    `APU_ASSERT_IMPL(a_stall_freeze, clk, rst_n, out_valid && out_stall, in_stall)
    `APU_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `APU_ASSERT_NEXT(a_valid_shift, clk, rst_n, !in_stall && in_valid, v_reg[0])
endmodule
`default_nettype wire

### hw/rtl/apu_sin.sv
// pipelined quadrant polynomial sine, q15 result, four register stages
`default_nettype none
module apu_sin (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [apu_pkg::ANGLE_BITS-1:0]      ang,
    output logic signed [16:0]                       sin_q15
);
    localparam int QB = apu_pkg::ANGLE_BITS - 2;

    logic [1:0]  quad;
    logic [QB-1:0] q;
    logic [15:0] z0;
    logic [15:0] z;
    logic [31:0] zz;

    assign quad = ang[apu_pkg::ANGLE_BITS-1 -: 2];
    assign q    = ang[QB-1:0];
    assign zz   = 32'({q, 15'd0} >> QB);
    assign z0   = zz[15:0];
    assign z    = quad[0] ? 16'(17'd32768 - {1'b0, z0}) : z0;

    // stage a: z and z squared
    logic [15:0] za_reg, z2a_reg;
    logic        nega_reg;
    logic [31:0] p_a;
    assign p_a = 32'(z) * 32'(z);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            za_reg   <= z;
            z2a_reg  <= p_a[30:15];
            nega_reg <= quad[1];
        end
    end

    // stage b: 21024 - 2320*z2
    logic [15:0] zb_reg, z2b_reg, tb_reg;
    logic        negb_reg;
    logic [31:0] p_b;
    assign p_b = 32'd2320 * 32'(z2a_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zb_reg   <= za_reg;
            z2b_reg  <= z2a_reg;
            tb_reg   <= 16'(17'd21024 - 17'(p_b[31:15]));
            negb_reg <= nega_reg;
        end
    end

    // stage c: 51472 - t*z2
    logic [15:0] zc_reg, tc_reg;
    logic        negc_reg;
    logic [31:0] p_c;
    assign p_c = 32'(tb_reg) * 32'(z2b_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zc_reg   <= zb_reg;
            tc_reg   <= 16'(17'd51472 - 17'(p_c[31:15]));
            negc_reg <= negb_reg;
        end
    end

    // stage d: t*z and sign
    logic [31:0] p_d;
    logic [16:0] s_mag;
    assign p_d   = 32'(tc_reg) * 32'(zc_reg);
    assign s_mag = p_d[31:15];
    always_ff @(posedge clk)
    begin
        if (en)
            sin_q15 <= negc_reg ? -$signed(s_mag) : $signed(s_mag);
    end
endmodule
`default_nettype wire
